[src/mlfd_pkg.sv]
// ----------------------------------------------------------------------------
// mlfd_pkg
// Shared types and constants for the magic-word, length-prefixed deframer.
// ----------------------------------------------------------------------------
package mlfd_pkg;

  // Register reset values and defaults
  localparam logic [31:0] MAGIC_WORD_RST      = 32'hAA55_AA55;
  localparam logic [17:0] MAX_PAYLOAD_RST     = 18'd131072;
  localparam int unsigned MAX_FRAME_BYTES_DEF = 131072;
  localparam int unsigned FIFO_DEPTH_DEF      = 4;

  // Configuration register indexes
  localparam logic REG_MAGIC_WORD  = 1'b0;
  localparam logic REG_MAX_PAYLOAD = 1'b1;

  // Input item kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_DROP = 1'b1;

  // Result kinds
  localparam logic RES_PAYLOAD = 1'b0;
  localparam logic RES_BAD_LEN = 1'b1;

  localparam int unsigned OFFSET_W = 17;

  // One classified result, handed from the parser to the output stage
  typedef struct packed {
    logic                res_kind;
    logic [7:0]          data;
    logic [OFFSET_W-1:0] offset;
    logic                last;
    logic [31:0]         length;
  } mlfd_cmd_t;

endpackage

[src/magic_length_frame_deframer.sv]
// ----------------------------------------------------------------------------
// magic_length_frame_deframer
// Byte-stream deframer: sync word, 4-byte big-endian length, tagged payload.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one transfer per byte (tuser = 0) or per link drop
//   (tuser = 1). A link drop discards any partial frame and resumes hunting.
//   Output stream: one transfer per payload byte (tuser = 0), or one per
//   rejected length (tuser = 1); tlast marks the final byte of a frame.
//   Throughput: one input transfer per cycle, sustained, as long as the
//   receiver takes results. A result passes through the queue write, then
//   the output register, before it appears on the output.
//   A 4-entry queue sits between the parser and the output register; the
//   input stalls (tready low) only while that queue is full, so the parser
//   keeps running while the receiver holds tready low, until that queue fills.
//   Reset: hunting, sync window zero, bank 0, frame count zero, registers at
//   their defaults (magic 0xAA55AA55, max payload 131072), queue empty.
//   Configuration: write magic_word (index 0) or max_payload (index 1) only
//   while the block is idle; other indexes are ignored.
// ----------------------------------------------------------------------------
module magic_length_frame_deframer import mlfd_pkg::*; #(
  parameter int unsigned MaxFrameBytes = MAX_FRAME_BYTES_DEF,
  parameter int unsigned FifoDepth     = FIFO_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  logic        s_axis_tuser,   // [0] kind
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] data_out, [24:8] byte_offset, [25] bank, [57:26] frame_length,
  // [89:58] frame_count, [95:90] zero
  output logic [95:0] m_axis_tdata,
  output logic        m_axis_tuser,   // [0] result_kind
  output logic        m_axis_tlast    // last
);

  logic [31:0] magic_q;
  logic [17:0] max_payload_q;

  mlfd_cmd_t   push_cmd, pop_cmd, out_cmd;
  logic        push, full, fifo_valid, pop;
  logic        out_bank;
  logic [31:0] out_index;

  // Configuration registers: take a write on any enabled edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q       <= MAGIC_WORD_RST;
      max_payload_q <= MAX_PAYLOAD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAGIC_WORD:  magic_q       <= cfg_data_i;
        REG_MAX_PAYLOAD: max_payload_q <= cfg_data_i[17:0];
        default: ;
      endcase
    end
  end

  // Parser: classify each accepted byte
  mlfd_front #(
    .MaxFrameBytes(MaxFrameBytes)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_kind_i    (s_axis_tuser),
    .in_byte_i    (s_axis_tdata),
    .in_ready_o   (s_axis_tready),
    .magic_word_i (magic_q),
    .max_payload_i(max_payload_q),
    .push_o       (push),
    .cmd_o        (push_cmd),
    .full_i       (full)
  );

  // Queue of pending results
  mlfd_fifo #(
    .Depth(FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(push_cmd),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(fifo_valid),
    .rdata_o(pop_cmd)
  );

  // Output stage: attach bank and frame count, hold until the transfer
  mlfd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(fifo_valid),
    .cmd_i      (pop_cmd),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_cmd_o  (out_cmd),
    .out_bank_o (out_bank),
    .out_index_o(out_index)
  );

  assign m_axis_tdata = {6'd0, out_index, out_cmd.length, out_bank,
                         out_cmd.offset, out_cmd.data};
  assign m_axis_tuser = out_cmd.res_kind;
  assign m_axis_tlast = out_cmd.last;

endmodule

[src/mlfd_front.sv]
// ----------------------------------------------------------------------------
// mlfd_front
// Parser: hunts for the sync word, assembles the length and tags payload bytes.
// ----------------------------------------------------------------------------
module mlfd_front import mlfd_pkg::*; #(
  parameter int unsigned MaxFrameBytes = MAX_FRAME_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_kind_i,
  input  logic [7:0]  in_byte_i,
  output logic        in_ready_o,
  input  logic [31:0] magic_word_i,
  input  logic [17:0] max_payload_i,
  output logic        push_o,
  output mlfd_cmd_t   cmd_o,
  input  logic        full_i
);

  localparam int unsigned OffW = $clog2(MaxFrameBytes);

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  logic [1:0]      phase_q, phase_d;
  logic [31:0]     window_q, window_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [31:0]     length_q, length_d;
  logic [OffW-1:0] offset_q, offset_d;

  logic        accept;
  logic [31:0] shifted_win;
  logic [31:0] shifted_len;
  logic [31:0] limit;
  logic [31:0] off_ext;
  logic [31:0] off_next;
  logic        is_last;
  logic        bad_len;

  assign in_ready_o  = ~full_i;
  assign accept      = in_valid_i & ~full_i;
  assign shifted_win = {window_q[23:0], in_byte_i};
  assign shifted_len = {length_q[23:0], in_byte_i};
  assign limit       = (32'(max_payload_i) > 32'(MaxFrameBytes)) ? 32'(MaxFrameBytes)
                                                                 : 32'(max_payload_i);
  assign bad_len     = (shifted_len == 32'd0) || (shifted_len > limit);
  assign off_ext     = 32'(offset_q);
  assign off_next    = off_ext + 32'd1;
  assign is_last     = off_next >= length_q;

  always_comb begin
    phase_d  = phase_q;
    window_d = window_q;
    cnt_d    = cnt_q;
    length_d = length_q;
    offset_d = offset_q;
    push_o   = 1'b0;
    cmd_o    = '0;
    if (accept) begin
      if (in_kind_i == KIND_DROP) begin
        phase_d  = PH_HUNT;
        window_d = '0;
        cnt_d    = '0;
        length_d = '0;
        offset_d = '0;
      end else begin
        case (phase_q)
          PH_LEN: begin
            length_d = shifted_len;
            cnt_d    = cnt_q + 2'd1;
            if (cnt_q == 2'd3) begin
              if (bad_len) begin
                push_o         = 1'b1;
                cmd_o.res_kind = RES_BAD_LEN;
                cmd_o.length   = shifted_len;
                phase_d        = PH_HUNT;
                window_d       = '0;
                cnt_d          = '0;
                length_d       = '0;
                offset_d       = '0;
              end else begin
                phase_d  = PH_DATA;
                offset_d = '0;
              end
            end
          end
          PH_DATA: begin
            push_o         = 1'b1;
            cmd_o.res_kind = RES_PAYLOAD;
            cmd_o.data     = in_byte_i;
            cmd_o.offset   = off_ext[OFFSET_W-1:0];
            cmd_o.last     = is_last;
            cmd_o.length   = length_q;
            if (is_last) begin
              phase_d  = PH_HUNT;
              window_d = '0;
              cnt_d    = '0;
              length_d = '0;
              offset_d = '0;
            end else begin
              offset_d = off_next[OffW-1:0];
            end
          end
          default: begin
            // hunting, or an unused code
            phase_d  = PH_HUNT;
            window_d = shifted_win;
            if (shifted_win == magic_word_i) begin
              phase_d  = PH_LEN;
              cnt_d    = '0;
              length_d = '0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      window_q <= '0;
      cnt_q    <= '0;
      length_q <= '0;
      offset_q <= '0;
    end else begin
      phase_q  <= phase_d;
      window_q <= window_d;
      cnt_q    <= cnt_d;
      length_q <= length_d;
      offset_q <= offset_d;
    end
  end

endmodule

[src/mlfd_fifo.sv]
// ----------------------------------------------------------------------------
// mlfd_fifo
// Short queue of classified results between parser and output stage.
// ----------------------------------------------------------------------------
module mlfd_fifo import mlfd_pkg::*; #(
  parameter int unsigned Depth = FIFO_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  mlfd_cmd_t wdata_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output mlfd_cmd_t rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  mlfd_cmd_t       mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrLast) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrLast) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[src/mlfd_back.sv]
// ----------------------------------------------------------------------------
// mlfd_back
// Output stage: keeps bank and frame count, holds the result register.
// ----------------------------------------------------------------------------
module mlfd_back import mlfd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  mlfd_cmd_t cmd_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output mlfd_cmd_t out_cmd_o,
  output logic      out_bank_o,
  output logic [31:0] out_index_o
);

  logic        valid_q;
  logic        bank_q;
  logic [31:0] frames_q;
  mlfd_cmd_t   cmd_q;
  logic        res_bank_q;
  logic [31:0] res_index_q;
  logic        load;
  logic        frame_end;

  assign load        = cmd_valid_i & (~valid_q | out_ready_i);
  assign pop_o       = load;
  assign frame_end   = (cmd_i.res_kind == RES_PAYLOAD) & cmd_i.last;
  assign out_valid_o = valid_q;
  assign out_cmd_o   = cmd_q;
  assign out_bank_o  = res_bank_q;
  assign out_index_o = res_index_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q       <= cmd_i;
      res_bank_q  <= bank_q;
      res_index_q <= frame_end ? frames_q + 32'd1 : frames_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      bank_q   <= 1'b0;
      frames_q <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
      if (load && frame_end) begin
        bank_q   <= ~bank_q;
        frames_q <= frames_q + 32'd1;
      end
    end
  end

endmodule
